FILE: sv/sce_pkg.sv
package sce_pkg;

  localparam int unsigned ENERGY_W  = 8;
  localparam int unsigned PENALTY_W = 20;
  localparam int unsigned LENGTH_W  = 12;
  localparam int unsigned CUM_W     = 32;
  localparam int unsigned CFG_IDX_W = 1;

  localparam int unsigned LINE_LENGTH_RST = 2048;
  localparam logic [PENALTY_W-1:0] PENALTY_RST = PENALTY_W'(100000);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PENALTY     = 1'b1;

  // Back offset codes, two's complement.
  localparam logic [1:0] OFFS_LOWER  = 2'b11;
  localparam logic [1:0] OFFS_SAME   = 2'b00;
  localparam logic [1:0] OFFS_HIGHER = 2'b01;

  // Previous-line neighborhood of the pixel being resolved.
  typedef struct packed {
    logic [CUM_W-1:0] left;
    logic [CUM_W-1:0] up;
    logic [CUM_W-1:0] right;
    logic             has_left;
    logic             has_right;
    logic             first;
  } sce_nbr_t;

endpackage

FILE: sv/sce_line_mem.sv
module sce_line_mem #(
  parameter int unsigned DEPTH = 2048,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [31:0]   wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_a_i,
  input  logic [AW-1:0] raddr_b_i,
  output logic [31:0]   rdata_a_o,
  output logic [31:0]   rdata_b_o
);

  logic [31:0] mem [DEPTH];
  logic [31:0] rdata_a_q;
  logic [31:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read data holds until the next read, so a waiting item keeps its operands.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_q <= mem[raddr_a_i];
      rdata_b_q <= mem[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

FILE: sv/sce_cost.sv
module sce_cost (
  input  sce_pkg::sce_nbr_t              nbr_i,
  input  logic [sce_pkg::PENALTY_W-1:0]  energy_i,
  output logic [sce_pkg::CUM_W-1:0]      cum_o,
  output logic [1:0]                     offs_o
);
  import sce_pkg::*;

  logic [CUM_W-1:0] best;
  logic [1:0]       offs;
  logic [CUM_W:0]   sum;

  // The lower position is taken first and only a strictly smaller value replaces it.
  always_comb begin
    best = nbr_i.up;
    offs = OFFS_SAME;
    if (nbr_i.has_left) begin
      best = nbr_i.left;
      offs = OFFS_LOWER;
      if (nbr_i.up < best) begin
        best = nbr_i.up;
        offs = OFFS_SAME;
      end
    end
    if (nbr_i.has_right && (nbr_i.right < best)) begin
      best = nbr_i.right;
      offs = OFFS_HIGHER;
    end
  end

  assign sum = {1'b0, best} + (CUM_W+1)'(energy_i);

  always_comb begin
    if (nbr_i.first) begin
      cum_o  = CUM_W'(energy_i);
      offs_o = OFFS_SAME;
    end else begin
      cum_o  = sum[CUM_W] ? {CUM_W{1'b1}} : sum[CUM_W-1:0];
      offs_o = offs;
    end
  end

endmodule

FILE: sv/seam_cumulative_energy.sv
// Channel   Direction  Handshake                  Payload
// in        input      in_valid_i / in_stall_o    energy_i, is_missing_i, frame_start_i
// out       output     out_valid_o / out_stall_i  cumulative_o, back_offset_o, line_end_o
// cfg       input      cfg_we_i                   cfg_idx_i, cfg_wdata_i
//
// One pixel per cycle sustained while the output is not stalled; a pixel's result passes
// the line-store read and then the output register before it can be taken at the output.
// The line store has two read ports and one write port, so the upper and upper-right
// neighbors are fetched in the cycle of acceptance and the result is written back when
// the pixel leaves the read stage.
// Reset clears control state only; line-store contents are undefined until written.
// A stalled output holds the result and the pixel in flight. With a pixel waiting in the
// read stage, in_stall_o rises in the same cycle as out_stall_i; with that stage empty,
// one more transaction is taken first.
module seam_cumulative_energy #(
  parameter int unsigned MAX_LINE = 2048
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [sce_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [sce_pkg::PENALTY_W-1:0]   cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [sce_pkg::ENERGY_W-1:0]    energy_i,
  input  logic                            is_missing_i,
  input  logic                            frame_start_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [sce_pkg::CUM_W-1:0]       cumulative_o,
  output logic signed [1:0]               back_offset_o,
  output logic                            line_end_o
);
  import sce_pkg::*;

  localparam int unsigned AW = $clog2(MAX_LINE);
  localparam int unsigned LEN_RST =
      (LINE_LENGTH_RST > MAX_LINE) ? MAX_LINE : LINE_LENGTH_RST;

  // Configuration
  logic [AW-1:0]        len_m1_q, len_m1_d;
  logic [PENALTY_W-1:0] penalty_q;
  logic [31:0]          cfg_len;

  // Position tracking
  logic [AW-1:0] cnt_q;
  logic          first_q;

  // Read stage
  logic                 s1_valid_q;
  logic [AW-1:0]        s1_pos_q;
  logic                 s1_first_q;
  logic                 s1_last_q;
  logic [PENALTY_W-1:0] s1_energy_q;
  logic                 fwd_up_q;
  logic                 fwd_rt_q;
  logic [CUM_W-1:0]     fwd_data_q;
  logic [CUM_W-1:0]     left_q;

  // Output register
  logic                 out_valid_q;
  logic [CUM_W-1:0]     cum_q;
  logic [1:0]           offs_q;
  logic                 line_end_q;

  logic                 out_free;
  logic                 s1_adv;
  logic                 in_acc;
  logic [AW-1:0]        acc_pos;
  logic [AW-1:0]        acc_pos_next;
  logic                 acc_first;
  logic                 acc_last;
  logic [PENALTY_W-1:0] acc_energy;
  logic [CUM_W-1:0]     rdata_up;
  logic [CUM_W-1:0]     rdata_rt;
  sce_nbr_t             nbr;
  logic [CUM_W-1:0]     cost_cum;
  logic [1:0]           cost_offs;

  // Handshake
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  // Position of the incoming pixel
  assign acc_pos      = frame_start_i ? '0 : cnt_q;
  assign acc_pos_next = AW'(acc_pos + 1'b1);
  assign acc_first    = frame_start_i || first_q;
  assign acc_last     = acc_pos >= len_m1_q;
  assign acc_energy   = is_missing_i ? penalty_q : PENALTY_W'(energy_i);

  // Out-of-range lengths clamp to the supported span.
  assign cfg_len = 32'(cfg_wdata_i[LENGTH_W-1:0]);
  always_comb begin
    if (cfg_len < 32'd2) begin
      len_m1_d = AW'(1);
    end else if (cfg_len > 32'(MAX_LINE)) begin
      len_m1_d = AW'(MAX_LINE - 1);
    end else begin
      len_m1_d = AW'(cfg_len - 32'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_m1_q  <= AW'(LEN_RST - 1);
      penalty_q <= PENALTY_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LINE_LENGTH: len_m1_q  <= len_m1_d;
        CFG_PENALTY:     penalty_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      first_q <= 1'b1;
    end else if (in_acc) begin
      if (acc_last) begin
        cnt_q   <= '0;
        first_q <= 1'b0;
      end else begin
        cnt_q   <= acc_pos_next;
        first_q <= acc_first;
      end
    end
  end

  sce_line_mem #(
    .DEPTH (MAX_LINE)
  ) u_line_mem (
    .clk_i     (clk_i),
    .we_i      (s1_adv),
    .waddr_i   (s1_pos_q),
    .wdata_i   (cost_cum),
    .re_i      (in_acc),
    .raddr_a_i (acc_pos),
    .raddr_b_i (acc_pos_next),
    .rdata_a_o (rdata_up),
    .rdata_b_o (rdata_rt)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  // A write retiring in the cycle of a read of the same entry is forwarded.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_pos_q    <= acc_pos;
      s1_first_q  <= acc_first;
      s1_last_q   <= acc_last;
      s1_energy_q <= acc_energy;
      fwd_up_q    <= s1_adv && (s1_pos_q == acc_pos);
      fwd_rt_q    <= s1_adv && (s1_pos_q == acc_pos_next);
      fwd_data_q  <= cost_cum;
    end
  end

  assign nbr.left      = left_q;
  assign nbr.up        = fwd_up_q ? fwd_data_q : rdata_up;
  assign nbr.right     = fwd_rt_q ? fwd_data_q : rdata_rt;
  assign nbr.has_left  = s1_pos_q != '0;
  assign nbr.has_right = !s1_last_q;
  assign nbr.first     = s1_first_q;

  sce_cost u_cost (
    .nbr_i    (nbr),
    .energy_i (s1_energy_q),
    .cum_o    (cost_cum),
    .offs_o   (cost_offs)
  );

  // The upper value of this pixel is the upper-left neighbor of the next one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= '0;
    end else if (s1_adv && !s1_first_q) begin
      left_q <= nbr.up;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_adv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      cum_q      <= cost_cum;
      offs_q     <= cost_offs;
      line_end_q <= s1_last_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign cumulative_o  = cum_q;
  assign back_offset_o = offs_q;
  assign line_end_o    = line_end_q;

  a_offs_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (offs_q == OFFS_LOWER || offs_q == OFFS_SAME || offs_q == OFFS_HIGHER))
    else $error("illegal back offset on output");

  a_first_line_same: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && s1_first_q) |=> (offs_q == OFFS_SAME && cum_q == CUM_W'($past(s1_energy_q))))
    else $error("first-line pixel not passed through");

  a_sum_covers_energy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |-> (cost_cum >= CUM_W'(s1_energy_q)))
    else $error("cumulative value below pixel energy");

  a_count_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !acc_last) |=> (cnt_q != '0 && !s1_last_q))
    else $error("position counter failed to advance within a line");

endmodule
